// ===== hw/rtl/battery_percent_estimator_top_assert.svh =====
// ----------------------------------------------------------------------------
// battery percent estimator assertion macros
// concurrent property wrappers used by battery_percent_estimator_top
// ----------------------------------------------------------------------------
`ifndef BATTERY_PERCENT_ESTIMATOR_TOP_ASSERT_SVH
`define BATTERY_PERCENT_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpe same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define BPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpe next-cycle check failed");

`endif

// ===== hw/rtl/bpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// types, constants and the voltage curve of the battery percent estimator
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [2:0] {
        RSN_GAUGE  = 3'd0,
        RSN_VOLT   = 3'd1,
        RSN_RATE   = 3'd2,
        RSN_NONE   = 3'd3,
        RSN_DROP   = 3'd4,
        RSN_CHARGE = 3'd5,
        RSN_DETACH = 3'd6,
        RSN_ZERO   = 3'd7
    } t_reason;

    typedef enum logic [2:0] {
        REG_MIN_INTERVAL   = 3'd0,
        REG_DETACH_WINDOW  = 3'd1,
        REG_DROP_GUARD     = 3'd2,
        REG_CHARGE_DROP    = 3'd3,
        REG_UNPLUG_DROP    = 3'd4,
        REG_VOLT_MARGIN    = 3'd5,
        REG_RISE_GUARD     = 3'd6,
        REG_ZERO_GUARD_MIN = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_BY_10,
        DIV_BY_5,
        DIV_BY_30
    } t_seg_div;

    typedef struct packed {
        logic [15:0] min_interval;
        logic [19:0] detach_window;
        logic [6:0]  drop_guard;
        logic [6:0]  charge_drop;
        logic [6:0]  unplug_drop;
        logic [6:0]  volt_margin;
        logic [6:0]  rise_guard;
        logic [6:0]  zero_guard_min;
    } t_bpe_cfg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               ext_power;
        logic               charging;
        logic [15:0]        gauge_mv;
        logic [15:0]        adc_mv;
        logic signed [7:0]  gauge_pct;
    } t_sample;

    typedef struct packed {
        logic signed [7:0] percent;
        t_reason           reason;
    } t_result;

    typedef struct packed {
        logic signed [7:0] last_pct;
        logic [31:0]       last_time;
        logic [31:0]       detach_time;
        logic              seen_power;
        logic              prev_vbus;
        logic              prev_charging;
        logic [1:0]        zero_count;
    } t_bpe_state;

    localparam t_bpe_cfg CFG_RESET = '{
        min_interval:   16'd1000,
        detach_window:  20'd120000,
        drop_guard:     7'd12,
        charge_drop:    7'd3,
        unplug_drop:    7'd5,
        volt_margin:    7'd10,
        rise_guard:     7'd2,
        zero_guard_min: 7'd15
    };

    localparam t_bpe_state STATE_RESET = '{
        last_pct:      -8'sd1,
        last_time:     32'd0,
        detach_time:   32'd0,
        seen_power:    1'b0,
        prev_vbus:     1'b0,
        prev_charging: 1'b0,
        zero_count:    2'd0
    };

    // lithium discharge curve, knee points from full to empty
    localparam logic [15:0] CURVE_MV [8] = '{
        16'd4200, 16'd4100, 16'd4000, 16'd3900,
        16'd3800, 16'd3700, 16'd3600, 16'd3300
    };
    localparam logic [6:0] CURVE_PCT [8] = '{
        7'd100, 7'd90, 7'd80, 7'd60, 7'd40, 7'd20, 7'd10, 7'd0
    };
    // slope of each segment as a constant divide
    localparam t_seg_div SEG_DIV [7] = '{
        DIV_BY_10, DIV_BY_10, DIV_BY_5, DIV_BY_5, DIV_BY_5, DIV_BY_10, DIV_BY_30
    };

    // voltage to percent, -1 for an invalid reading
    function automatic logic signed [7:0] mv_to_pct(input logic [15:0] mv);
        logic [2:0]  seg;
        logic [2:0]  seg_lo;
        logic        found;
        logic [8:0]  d;
        logic [19:0] prod;
        logic [6:0]  off;
        logic signed [7:0] res;
        seg   = '0;
        found = 1'b0;
        for (int i = 0; i < 7; i++) begin
            if (!found && mv <= CURVE_MV[i] && mv >= CURVE_MV[i + 1]) begin
                seg   = 3'(i);
                found = 1'b1;
            end
        end
        seg_lo = seg + 3'd1;
        d      = 9'(mv - CURVE_MV[seg_lo]);
        prod   = '0;
        off    = '0;
        case (SEG_DIV[seg])
            DIV_BY_10: begin
                prod = 20'(d) * 20'd205;
                off  = 7'(prod >> 11);
            end
            DIV_BY_5: begin
                prod = 20'(d) * 20'd205;
                off  = 7'(prod >> 10);
            end
            DIV_BY_30: begin
                prod = 20'(d) * 20'd1093;
                off  = 7'(prod >> 15);
            end
            default: begin
                prod = '0;
                off  = '0;
            end
        endcase
        if (mv == 16'd0) begin
            res = -8'sd1;
        end else if (mv >= CURVE_MV[0]) begin
            res = 8'sd100;
        end else if (mv <= CURVE_MV[7]) begin
            res = 8'sd0;
        end else begin
            res = $signed({1'b0, 7'(CURVE_PCT[seg_lo] + off)});
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bpe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe channel interfaces
// sample, result and register write channels with valid/ready handshakes
// ----------------------------------------------------------------------------
interface bpe_sample_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic               ext_power;
    logic               charging;
    logic [15:0]        gauge_mv;
    logic [15:0]        adc_mv;
    logic signed [7:0]  gauge_pct;

    modport source (output valid, now_ms, ext_power, charging, gauge_mv, adc_mv,
                    gauge_pct, input ready);
    modport sink   (input valid, now_ms, ext_power, charging, gauge_mv, adc_mv,
                    gauge_pct, output ready);
endinterface

interface bpe_result_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] percent;
    logic [2:0]        reason;

    modport source (output valid, percent, reason, input ready);
    modport sink   (input valid, percent, reason, output ready);
endinterface

interface bpe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/battery_percent_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_percent_estimator_top
// smoothed battery percent from timestamped power, voltage and gauge samples
// ----------------------------------------------------------------------------
//  channel  dir  handshake     beat contents
//  i_smp    in   valid/ready   now_ms, ext_power, charging, gauge_mv, adc_mv,
//                              gauge_pct
//  o_res    out  valid/ready   percent (-1 unknown), reason code
//  i_cfg    in   valid/ready   register index, write data (always ready)
//
//  a sample beat goes first into the sample register, then evaluation lands
//  in the result register together with the state update, so a new sample
//  can be taken every cycle while the result side is not stalled
//  reset is synchronous active low; registers go to their defaults, the
//  percent to unknown and no beat is pending on either side
//  a stalled result holds the sample register, which then drops i_smp.ready
// ----------------------------------------------------------------------------
module battery_percent_estimator_top
    import bpe_pkg::*;
#(
    parameter int ZERO_GUARD_COUNT = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpe_sample_if.sink    i_smp,
    bpe_result_if.source  o_res,
    bpe_cfg_if.sink       i_cfg
);

    `include "battery_percent_estimator_top_assert.svh"

    // configuration registers
    t_bpe_cfg   r_cfg;
    t_bpe_cfg   n_cfg;

    // sample register
    logic       r_smp_valid;
    t_sample    r_smp;

    // result register
    logic       r_res_valid;
    t_result    r_res;

    // estimator state
    t_bpe_state r_state;

    t_result    w_res;
    t_bpe_state w_state;
    t_sample    w_smp_in;
    logic       w_adv;
    logic       w_take;

    // sample moves on when the result slot is empty or being drained
    assign w_adv  = r_smp_valid && (!r_res_valid || o_res.ready);
    assign i_smp.ready = !r_smp_valid || w_adv;
    assign w_take = i_smp.valid && i_smp.ready;

    assign w_smp_in = '{
        now_ms:       i_smp.now_ms,
        ext_power:    i_smp.ext_power,
        charging:     i_smp.charging,
        gauge_mv:     i_smp.gauge_mv,
        adc_mv:       i_smp.adc_mv,
        gauge_pct:    i_smp.gauge_pct
    };

    // the user must write registers only while idle; the block does not enforce it and always accepts
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_MIN_INTERVAL:   n_cfg.min_interval   = i_cfg.data[15:0];
                REG_DETACH_WINDOW:  n_cfg.detach_window  = i_cfg.data;
                REG_DROP_GUARD:     n_cfg.drop_guard     = i_cfg.data[6:0];
                REG_CHARGE_DROP:    n_cfg.charge_drop    = i_cfg.data[6:0];
                REG_UNPLUG_DROP:    n_cfg.unplug_drop    = i_cfg.data[6:0];
                REG_VOLT_MARGIN:    n_cfg.volt_margin    = i_cfg.data[6:0];
                REG_RISE_GUARD:     n_cfg.rise_guard     = i_cfg.data[6:0];
                REG_ZERO_GUARD_MIN: n_cfg.zero_guard_min = i_cfg.data[6:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_valid <= 1'b0;
        end else if (w_take) begin
            r_smp_valid <= 1'b1;
        end else if (w_adv) begin
            r_smp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_smp <= w_smp_in;
        end
    end

    // curve, rate limit and guards in one pass
    bpe_eval #(
        .ZERO_GUARD_COUNT (ZERO_GUARD_COUNT)
    ) u_eval (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_smp   (r_smp),
        .o_res   (w_res),
        .o_state (w_state)
    );

    // state commits with the result beat it belongs to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_adv) begin
            r_state <= w_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_adv) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.percent = r_res.percent;
    assign o_res.reason  = r_res.reason;

    // reported percent is unknown or a real percent
    `BPE_ASSERT_NOW(a_pct_range, i_clk, i_rst_n, r_res_valid,
        (r_res.percent == -8'sd1) || (r_res.percent >= 8'sd0 && r_res.percent <= 8'sd100))

    // zero streak never runs past its limit
    `BPE_ASSERT_NOW(a_zero_cnt, i_clk, i_rst_n, 1'b1,
        r_state.zero_count <= 2'(ZERO_GUARD_COUNT))

    // a held sample must not be overwritten
    `BPE_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_smp_valid && !w_adv, !i_smp.ready)

    // state only moves when a result beat is produced
    `BPE_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !w_adv, r_state == $past(r_state))

endmodule

// ===== hw/rtl/bpe_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_eval
// one-sample evaluation: curve, rate limit, guards and next state
// ----------------------------------------------------------------------------
module bpe_eval
    import bpe_pkg::*;
#(
    parameter int ZERO_GUARD_COUNT = 3
) (
    input  t_bpe_cfg   i_cfg,
    input  t_bpe_state i_state,
    input  t_sample    i_smp,
    output t_result    o_res,
    output t_bpe_state o_state
);

    logic              was_pw;
    logic              is_pw;
    logic              chg;
    logic [31:0]       detach_new;
    logic              rate_hit;
    logic signed [7:0] vp_g;
    logic signed [7:0] vp_a;
    logic signed [7:0] vp;
    logic signed [9:0] vp10;
    logic signed [9:0] last10;
    logic signed [9:0] level;
    t_reason           reason;
    logic              in_win;
    logic              volt_backs;
    logic              zero_cond;

    assign vp_g = mv_to_pct(i_smp.gauge_mv);
    assign vp_a = mv_to_pct(i_smp.adc_mv);

    always_comb begin
        was_pw = i_state.seen_power && (i_state.prev_vbus || i_state.prev_charging);
        is_pw  = i_smp.ext_power || i_smp.charging;
        chg    = i_smp.charging;

        o_state               = i_state;
        o_state.seen_power    = 1'b1;
        o_state.prev_vbus     = i_smp.ext_power;
        o_state.prev_charging = i_smp.charging;
        detach_new = (was_pw && !is_pw) ? i_smp.now_ms : i_state.detach_time;
        o_state.detach_time   = detach_new;

        last10   = 10'(i_state.last_pct);
        rate_hit = (i_state.last_pct >= 0) && (i_state.last_time != 32'd0)
                   && ((i_smp.now_ms - i_state.last_time) < {16'd0, i_cfg.min_interval});

        // gauge voltage first, converter voltage as fallback
        vp   = (vp_g < 0) ? vp_a : vp_g;
        vp10 = 10'(vp);

        // clamped gauge percent, else the curve
        if (i_smp.gauge_pct < 0) begin
            level  = vp10;
            reason = RSN_VOLT;
        end else if (i_smp.gauge_pct > 8'sd100) begin
            level  = 10'sd100;
            reason = RSN_GAUGE;
        end else begin
            level  = 10'(i_smp.gauge_pct);
            reason = RSN_GAUGE;
        end

        in_win = (detach_new != 32'd0)
                 && ((i_smp.now_ms - detach_new) <= {12'd0, i_cfg.detach_window});
        volt_backs = (vp10 >= 0) && (last10 >= 0)
                     && (vp10 + $signed({3'd0, i_cfg.volt_margin}) >= last10);
        zero_cond  = 1'b0;

        o_res.percent = i_state.last_pct;
        o_res.reason  = RSN_RATE;

        if (rate_hit) begin
            o_res.reason = RSN_RATE;
        end else if (level < 0) begin
            o_state.last_time = i_smp.now_ms;
            o_res.reason      = RSN_NONE;
        end else begin
            if (last10 >= 0) begin
                if (!chg && level > last10 + $signed({3'd0, i_cfg.rise_guard})) begin
                    level  = last10;
                    reason = RSN_DROP;
                end
                if (chg && level + $signed({3'd0, i_cfg.charge_drop}) < last10) begin
                    level  = last10;
                    reason = RSN_CHARGE;
                end
                if (!is_pw && in_win && volt_backs
                    && level + $signed({3'd0, i_cfg.unplug_drop}) < last10) begin
                    level  = last10;
                    reason = RSN_DETACH;
                end
                if (!chg && volt_backs
                    && level + $signed({3'd0, i_cfg.drop_guard}) < last10) begin
                    level  = last10;
                    reason = RSN_DROP;
                end
            end

            zero_cond = !chg && (level == 10'sd0)
                        && (last10 >= $signed({3'd0, i_cfg.zero_guard_min}));
            o_state.last_time = i_smp.now_ms;
            if (zero_cond && (i_state.zero_count < 2'(ZERO_GUARD_COUNT))) begin
                // suspect zero, hold and count it
                o_state.zero_count = i_state.zero_count + 2'd1;
                o_res.reason       = RSN_ZERO;
            end else begin
                if (!zero_cond) begin
                    o_state.zero_count = 2'd0;
                end
                o_state.last_pct = 8'(level);
                o_res.percent    = 8'(level);
                o_res.reason     = reason;
            end
        end
    end

endmodule
